@@ sv/tlik_pkg.sv @@
`default_nettype none
package tlik_pkg;

    localparam int COORD_BITS      = 11;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int LINK_BITS       = 10;

    localparam int CFG_W      = (COORD_BITS > LINK_BITS) ? COORD_BITS : LINK_BITS;
    localparam int CFG_IDX_W  = 2;

    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int D2_W       = 2 * COORD_BITS + 1;
    localparam int N_W        = D2_W + 1;
    localparam int PROD_W     = 2 * LINK_BITS;
    localparam int SSQ_W      = PROD_W + 1;
    localparam int D_W        = PROD_W + 1;
    localparam int SQSUM_W    = 2 * (LINK_BITS + 1);
    localparam int SQ_W       = 2 * D_W + 4;
    localparam int ROOT_W     = D_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_K_W   = $clog2(SQRT_STEPS);

    localparam int ARG_W      = 40;
    localparam int NORM_TOP   = ARG_W;
    localparam int M_W        = ARG_W + 1;
    localparam int CORDIC_W   = ARG_W + 4;
    localparam int Z_W        = 36;
    localparam int NORM_STEPS = 6;
    localparam int CORDIC_STEPS = 30;
    localparam int IDX_W      = $clog2(CORDIC_STEPS);

    localparam int SHOULDER_W = ANGLE_FRAC_BITS + 3;
    localparam int ELBOW_W    = ANGLE_FRAC_BITS + 2;
    localparam int RND_SH     = 30 - ANGLE_FRAC_BITS;

    localparam logic signed [Z_W-1:0] PI_Q30     = 36'sd3373259426;
    localparam logic signed [Z_W:0]   TWO_PI_Q30 = 37'sd6746518852;

    // pipeline stage numbers, counted from the input transfer
    localparam int ST_SQRT_IN  = 5;
    localparam int ST_SQRT_OUT = ST_SQRT_IN + SQRT_STEPS;
    localparam int ST_PROD     = ST_SQRT_OUT + 1;
    localparam int ST_ARG      = ST_PROD + 1;
    localparam int ATAN_LAT    = 1 + NORM_STEPS + CORDIC_STEPS;
    localparam int ST_ANG      = ST_ARG + ATAN_LAT;
    localparam int ST_DIFF     = ST_ANG + 1;

    localparam logic [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        36'h03243F6A8, 36'h01DAC6705, 36'h00FADBAFC, 36'h007F56EA6, 36'h003FEAB76,
        36'h001FFD55B, 36'h000FFFAAA, 36'h0007FFF55, 36'h0003FFFEA, 36'h0001FFFFD,
        36'h0000FFFFF, 36'h00007FFFF, 36'h00003FFFF, 36'h00001FFFF, 36'h00000FFFF,
        36'h000007FFF, 36'h000003FFF, 36'h000001FFF, 36'h000000FFF, 36'h0000007FF,
        36'h0000003FF, 36'h0000001FF, 36'h0000000FF, 36'h00000007F, 36'h00000003F,
        36'h00000001F, 36'h00000000F, 36'h000000008, 36'h000000004, 36'h000000002
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINK1  = 2'd0,
        REG_LINK2  = 2'd1,
        REG_ORIG_X = 2'd2,
        REG_ORIG_Y = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic [COORD_BITS-1:0] target_x;
        logic [COORD_BITS-1:0] target_y;
    } in_item_t;

    typedef struct packed {
        logic signed [SHOULDER_W-1:0] shoulder_angle;
        logic [ELBOW_W-1:0]           elbow_angle;
        logic                         unreachable;
    } out_item_t;

    typedef struct packed {
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic signed [N_W-1:0]     n;
        logic                      unr;
    } side_t;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [Z_W-1:0]      z;
        logic                       zero;
    } cordic_t;

endpackage
`default_nettype wire

@@ sv/tlik_sqrt_cell.sv @@
`default_nettype none
module tlik_sqrt_cell (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [tlik_pkg::SQRT_K_W-1:0] k,
    input  wire logic [tlik_pkg::SQ_W-1:0]     rem_in,
    input  wire logic [tlik_pkg::SQ_W-1:0]     res_in,
    output logic      [tlik_pkg::SQ_W-1:0]     rem_out,
    output logic      [tlik_pkg::SQ_W-1:0]     res_out
);
    import tlik_pkg::*;

    logic [SQ_W-1:0] bit_w;
    logic [SQ_W-1:0] trial_w;
    logic [SQ_W-1:0] rem_reg, rem_next;
    logic [SQ_W-1:0] res_reg, res_next;

    always_comb
    begin
        bit_w   = SQ_W'(1) << {k, 1'b0};
        trial_w = res_in + bit_w;
        if (rem_in >= trial_w)
        begin
            rem_next = rem_in - trial_w;
            res_next = (res_in >> 1) + bit_w;
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            res_reg <= res_next;
        end
    end

    assign rem_out = rem_reg;
    assign res_out = res_reg;
endmodule
`default_nettype wire

@@ sv/tlik_cordic_cell.sv @@
`default_nettype none
module tlik_cordic_cell (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [tlik_pkg::IDX_W-1:0] idx,
    input  wire tlik_pkg::cordic_t          d_in,
    output tlik_pkg::cordic_t               d_out
);
    import tlik_pkg::*;

    logic signed [CORDIC_W-1:0] xs_w;
    logic signed [CORDIC_W-1:0] ys_w;
    logic signed [Z_W-1:0]      at_w;
    cordic_t d_reg, d_next;

    always_comb
    begin
        xs_w   = d_in.x >>> idx;
        ys_w   = d_in.y >>> idx;
        at_w   = $signed(ATAN_TAB[idx]);
        d_next = d_in;
        if (!d_in.zero)
        begin
            if (d_in.y > 0)
            begin
                d_next.x = d_in.x + ys_w;
                d_next.y = d_in.y - xs_w;
                d_next.z = d_in.z + at_w;
            end
            else
            begin
                d_next.x = d_in.x - ys_w;
                d_next.y = d_in.y + xs_w;
                d_next.z = d_in.z - at_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

@@ sv/tlik_atan2.sv @@
`default_nettype none
module tlik_atan2 (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic signed [tlik_pkg::ARG_W-1:0] y_in,
    input  wire logic signed [tlik_pkg::ARG_W-1:0] x_in,
    output logic signed      [tlik_pkg::Z_W-1:0]   angle
);
    import tlik_pkg::*;

    cordic_t        st_reg [NORM_STEPS+1];
    logic [M_W-1:0] m_reg  [NORM_STEPS+1];
    cordic_t        fold_next;
    logic [M_W-1:0] m_next;
    logic signed [ARG_W-1:0] xf_w, yf_w, ya_w;
    cordic_t        c_w    [CORDIC_STEPS+1];

    // fold the left half plane by pi, then take the larger magnitude
    always_comb
    begin
        fold_next.z = '0;
        xf_w = x_in;
        yf_w = y_in;
        if (x_in < 0)
        begin
            fold_next.z = (y_in >= 0) ? PI_Q30 : -PI_Q30;
            xf_w = -x_in;
            yf_w = -y_in;
        end
        ya_w = (yf_w < 0) ? -yf_w : yf_w;
        fold_next.x    = CORDIC_W'(xf_w);
        fold_next.y    = CORDIC_W'(yf_w);
        fold_next.zero = (xf_w == '0) && (yf_w == '0);
        m_next = (xf_w > ya_w) ? M_W'(xf_w) : M_W'(ya_w);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= fold_next;
            m_reg[0]  <= m_next;
        end
    end

    // normalise in binary steps so the larger magnitude lands in the top bit
    for (genvar i = 0; i < NORM_STEPS; i++)
    begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - i);
        logic do_shift;
        cordic_t norm_next;
        logic [M_W-1:0] mn_next;
        assign do_shift = (m_reg[i] >> (NORM_TOP - SH)) == '0;
        always_comb
        begin
            norm_next = st_reg[i];
            mn_next   = m_reg[i];
            if (do_shift)
            begin
                norm_next.x = st_reg[i].x <<< SH;
                norm_next.y = st_reg[i].y <<< SH;
                mn_next     = m_reg[i] << SH;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i+1] <= norm_next;
                m_reg[i+1]  <= mn_next;
            end
        end
    end

    assign c_w[0] = st_reg[NORM_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        tlik_cordic_cell u_cell (
            .clk   (clk),
            .en    (en),
            .idx   (IDX_W'(i)),
            .d_in  (c_w[i]),
            .d_out (c_w[i+1])
        );
    end

    assign angle = c_w[CORDIC_STEPS].z;
endmodule
`default_nettype wire

@@ sv/two_link_inverse_kinematics.sv @@
// channel  | direction | handshake          | payload
// in       | in        | in_valid/in_stall  | in_data    (target_x, target_y)
// out      | out       | out_valid/out_stall| out_data   (shoulder, elbow, flag)
// cfg      | in        | cfg_we             | cfg_index, cfg_data
//
// One target per cycle while the chain is not held; each result passes
// through the 21 square-root cells and the 37 atan2 stages (fold, six
// normalise steps, 30 rotation cells). The whole chain advances together
// and holds while the output register is full and stalled. Reset clears
// the valid bits and loads the link and origin registers.
`default_nettype none
module two_link_inverse_kinematics (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire tlik_pkg::in_item_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output tlik_pkg::out_item_t                   out_data,
    input  wire logic                             cfg_we,
    input  wire logic [tlik_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tlik_pkg::CFG_W-1:0]       cfg_data
);
    import tlik_pkg::*;

    logic [LINK_BITS-1:0]  link1_reg, link2_reg;
    logic [COORD_BITS-1:0] orig_x_reg, orig_y_reg;

    logic [PROD_W-1:0]  l1l2_reg, l1sq_reg, l2sq_reg, sqdif_reg;
    logic [SQSUM_W-1:0] sqsum_reg;
    logic [SSQ_W-1:0]   ssq_reg;
    logic [D_W-1:0]     d_w;
    logic [SQ_W-1:0]    dsq_reg;
    logic [LINK_BITS:0] lsum_w;
    logic [LINK_BITS-1:0] ldif_w;

    logic adv;
    logic vld_reg [1:ST_DIFF];
    logic out_valid_reg;

    side_t side_reg [1:ST_ARG];
    side_t side1_next, side3_next;
    logic [D2_W-1:0] d2_reg;
    logic signed [2*DELTA_W-1:0] dxsq_w, dysq_w;
    logic signed [2*N_W-1:0] nsq_w;
    logic [SQ_W-1:0] nsq_reg, rad_reg;

    logic [SQ_W-1:0] rem_w [SQRT_STEPS+1];
    logic [SQ_W-1:0] res_w [SQRT_STEPS+1];

    logic [ROOT_W-1:0] root_reg, root2_reg;
    logic [LINK_BITS+ROOT_W-1:0] y2_reg, y2a_reg;
    logic [LINK_BITS+D_W-1:0] p1_reg;
    logic signed [LINK_BITS+N_W:0] p2_reg;
    logic signed [ARG_W-1:0] x2_reg;

    logic signed [Z_W-1:0] ang_tgt_w, ang_elb_w, ang_cor_w;
    logic unr_reg [ST_ARG+1:ST_DIFF];
    logic signed [Z_W:0] diff_w, diff_next, diff_reg;
    logic signed [Z_W-1:0] elb_reg;
    logic signed [Z_W:0] sh_rnd_w, el_rnd_w;
    out_item_t out_reg, out_next;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link1_reg  <= LINK_BITS'(60);
            link2_reg  <= LINK_BITS'(60);
            orig_x_reg <= '0;
            orig_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_LINK1:  link1_reg  <= cfg_data[LINK_BITS-1:0];
                REG_LINK2:  link2_reg  <= cfg_data[LINK_BITS-1:0];
                REG_ORIG_X: orig_x_reg <= cfg_data[COORD_BITS-1:0];
                REG_ORIG_Y: orig_y_reg <= cfg_data[COORD_BITS-1:0];
            endcase
        end
    end

    // terms that follow from the link lengths alone
    assign lsum_w = {1'b0, link1_reg} + {1'b0, link2_reg};
    assign ldif_w = (link1_reg > link2_reg) ? link1_reg - link2_reg : link2_reg - link1_reg;
    assign d_w    = {l1l2_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        l1l2_reg  <= link1_reg * link2_reg;
        l1sq_reg  <= link1_reg * link1_reg;
        l2sq_reg  <= link2_reg * link2_reg;
        sqsum_reg <= lsum_w * lsum_w;
        sqdif_reg <= ldif_w * ldif_w;
        ssq_reg   <= {1'b0, l1sq_reg} + {1'b0, l2sq_reg};
        dsq_reg   <= SQ_W'(d_w) * SQ_W'(d_w);
    end

    // the chain moves unless a finished result is held back
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= ST_DIFF; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1] <= in_valid;
            for (int i = 2; i <= ST_DIFF; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid_reg <= vld_reg[ST_DIFF];
        end
    end

    always_comb
    begin
        side1_next.dx  = $signed({1'b0, in_data.target_x}) - $signed({1'b0, orig_x_reg});
        side1_next.dy  = $signed({1'b0, in_data.target_y}) - $signed({1'b0, orig_y_reg});
        side1_next.n   = '0;
        side1_next.unr = 1'b0;
        dxsq_w = side_reg[1].dx * side_reg[1].dx;
        dysq_w = side_reg[1].dy * side_reg[1].dy;
        side3_next     = side_reg[2];
        side3_next.unr = (link1_reg == '0) || (link2_reg == '0)
                      || (d2_reg > D2_W'(sqsum_reg)) || (d2_reg < D2_W'(sqdif_reg));
        side3_next.n   = N_W'($signed({1'b0, d2_reg}) - $signed({3'b0, ssq_reg}));
        nsq_w = side_reg[3].n * side_reg[3].n;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1] <= side1_next;
            side_reg[2] <= side_reg[1];
            d2_reg      <= D2_W'(dxsq_w + dysq_w);
            side_reg[3] <= side3_next;
            for (int i = 4; i <= ST_ARG; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            nsq_reg <= SQ_W'(nsq_w);
            rad_reg <= side_reg[4].unr ? '0 : dsq_reg - nsq_reg;
        end
    end

    assign rem_w[0] = rad_reg;
    assign res_w[0] = '0;

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        tlik_sqrt_cell u_cell (
            .clk     (clk),
            .en      (adv),
            .k       (SQRT_K_W'(SQRT_STEPS - 1 - j)),
            .rem_in  (rem_w[j]),
            .res_in  (res_w[j]),
            .rem_out (rem_w[j+1]),
            .res_out (res_w[j+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            root_reg  <= res_w[SQRT_STEPS][ROOT_W-1:0];
            y2_reg    <= link2_reg * res_w[SQRT_STEPS][ROOT_W-1:0];
            p1_reg    <= link1_reg * d_w;
            p2_reg    <= $signed({1'b0, link2_reg}) * side_reg[ST_PROD-1].n;
            root2_reg <= root_reg;
            y2a_reg   <= y2_reg;
            x2_reg    <= ARG_W'($signed({1'b0, p1_reg})) + ARG_W'(p2_reg);
        end
    end

    tlik_atan2 u_atan_tgt (
        .clk   (clk),
        .en    (adv),
        .y_in  (ARG_W'(side_reg[ST_ARG].dy)),
        .x_in  (ARG_W'(side_reg[ST_ARG].dx)),
        .angle (ang_tgt_w)
    );

    tlik_atan2 u_atan_elb (
        .clk   (clk),
        .en    (adv),
        .y_in  ($signed(ARG_W'(root2_reg))),
        .x_in  (ARG_W'(side_reg[ST_ARG].n)),
        .angle (ang_elb_w)
    );

    tlik_atan2 u_atan_cor (
        .clk   (clk),
        .en    (adv),
        .y_in  ($signed(ARG_W'(y2a_reg))),
        .x_in  (x2_reg),
        .angle (ang_cor_w)
    );

    // wrap the shoulder difference into (-pi, pi]
    always_comb
    begin
        diff_w = (Z_W+1)'(ang_tgt_w) - (Z_W+1)'(ang_cor_w);
        priority if (diff_w <= -(Z_W+1)'(PI_Q30))
        begin
            diff_next = diff_w + TWO_PI_Q30;
        end
        else if (diff_w > (Z_W+1)'(PI_Q30))
        begin
            diff_next = diff_w - TWO_PI_Q30;
        end
        else
        begin
            diff_next = diff_w;
        end
    end

    always_comb
    begin
        sh_rnd_w = (diff_reg + ((Z_W+1)'(1) <<< (RND_SH - 1))) >>> RND_SH;
        el_rnd_w = ((Z_W+1)'(elb_reg) + ((Z_W+1)'(1) <<< (RND_SH - 1))) >>> RND_SH;
        out_next.unreachable = unr_reg[ST_DIFF];
        if (unr_reg[ST_DIFF])
        begin
            out_next.shoulder_angle = '0;
            out_next.elbow_angle    = '0;
        end
        else
        begin
            out_next.shoulder_angle = sh_rnd_w[SHOULDER_W-1:0];
            out_next.elbow_angle    = el_rnd_w[ELBOW_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unr_reg[ST_ARG+1] <= side_reg[ST_ARG].unr;
            for (int i = ST_ARG + 2; i <= ST_DIFF; i++)
            begin
                unr_reg[i] <= unr_reg[i-1];
            end
            diff_reg <= diff_next;
            elb_reg  <= ang_elb_w;
            out_reg  <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

@@ sv/tlik_checker.sv @@
`default_nettype none
module tlik_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire tlik_pkg::in_item_t             in_data,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire tlik_pkg::out_item_t            out_data,
    input wire logic                           cfg_we,
    input wire logic [tlik_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire logic [tlik_pkg::CFG_W-1:0]     cfg_data
);
    import tlik_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // the input only waits behind a held result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.unreachable |->
            out_data.shoulder_angle == '0 && out_data.elbow_angle == '0)
        else $error("unreachable result with nonzero angles");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.elbow_angle <= ELBOW_W'(25736)
            && out_data.shoulder_angle <= SHOULDER_W'(25736)
            && out_data.shoulder_angle >= -SHOULDER_W'(25736))
        else $error("angle beyond pi");
endmodule

bind two_link_inverse_kinematics tlik_checker u_tlik_checker (.*);
`default_nettype wire
